// ===== src/fixed_point_alu_unit_assert.svh =====
// Assertion macros shared by the fixed-point ALU RTL.
`ifndef FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define FIXED_POINT_ALU_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define FXALU_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fixed_point_alu_unit: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define FXALU_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("fixed_point_alu_unit: next-cycle check failed");

`endif

// ===== src/fxalu_pkg.sv =====
// Shared types, command codes and defaults of the fixed-point ALU.
`timescale 1ns / 1ps

package fxalu_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int CMD_W          = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_INC      = 4'd6,
        CMD_DEC      = 4'd7,
        CMD_FROM_INT = 4'd8,
        CMD_TO_INT   = 4'd9
    } cmd_t;

    // How the cell chain treats a beat.
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_MUL   = 2'd1,
        KIND_DIV   = 2'd2
    } kind_t;

    // Control and flags that travel with every beat.
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  neg;
        logic  gt;
        logic  lt;
        logic  eq;
        logic  dz;
    } ctl_t;

endpackage

// ===== src/fxalu_prep.sv =====
// Operand decode: flags, single-step results and chain setup for mul and div.
`timescale 1ns / 1ps

module fxalu_prep #(
    parameter int WORD_WIDTH = fxalu_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic                                 in_valid,
    input  logic [fxalu_pkg::CMD_W-1:0]          command,
    input  logic signed [WORD_WIDTH-1:0]         operand_a,
    input  logic signed [WORD_WIDTH-1:0]         operand_b,
    output fxalu_pkg::ctl_t                      ctl,
    output logic [WORD_WIDTH+FRAC_BITS-1:0]      shreg,
    output logic [WORD_WIDTH-1:0]                m,
    output logic [WORD_WIDTH-1:0]                plain
);
    import fxalu_pkg::*;

    logic [WORD_WIDTH-1:0] mag_a;
    logic [WORD_WIDTH-1:0] mag_b;
    logic                  gt;
    logic                  lt;

    // Take magnitudes and compare the operands as signed words
    always_comb
    begin
        mag_a = operand_a[WORD_WIDTH-1] ? WORD_WIDTH'(-operand_a) : WORD_WIDTH'(operand_a);
        mag_b = operand_b[WORD_WIDTH-1] ? WORD_WIDTH'(-operand_b) : WORD_WIDTH'(operand_b);
        gt    = operand_a > operand_b;
        lt    = operand_a < operand_b;
    end

    // Decode the command
    always_comb
    begin
        ctl.valid = in_valid;
        ctl.kind  = KIND_PLAIN;
        ctl.neg   = operand_a[WORD_WIDTH-1] ^ operand_b[WORD_WIDTH-1];
        ctl.gt    = gt;
        ctl.lt    = lt;
        ctl.eq    = !gt && !lt;
        ctl.dz    = 1'b0;
        shreg     = '0;
        m         = '0;
        plain     = '0;
        unique case (cmd_t'(command))
            CMD_ADD:      plain = WORD_WIDTH'(operand_a + operand_b);
            CMD_SUB:      plain = WORD_WIDTH'(operand_a - operand_b);
            CMD_MUL:
            begin
                ctl.kind = KIND_MUL;
                shreg    = {{FRAC_BITS{1'b0}}, mag_b};
                m        = mag_a;
            end
            CMD_DIV:
            begin
                if (operand_b == '0)
                begin
                    ctl.dz = 1'b1;
                end
                else
                begin
                    ctl.kind = KIND_DIV;
                    shreg    = {mag_a, {FRAC_BITS{1'b0}}};
                    m        = mag_b;
                end
            end
            CMD_MIN:      plain = lt ? operand_a : operand_b;
            CMD_MAX:      plain = gt ? operand_a : operand_b;
            CMD_INC:      plain = WORD_WIDTH'(operand_a + WORD_WIDTH'(1));
            CMD_DEC:      plain = WORD_WIDTH'(operand_a - WORD_WIDTH'(1));
            CMD_FROM_INT: plain = WORD_WIDTH'(operand_a <<< FRAC_BITS);
            CMD_TO_INT:   plain = WORD_WIDTH'(operand_a >>> FRAC_BITS);
            default:      plain = '0;
        endcase
    end

endmodule

// ===== src/fxalu_cell.sv =====
// One registered cell: one shift-add multiply step, one restoring divide step, or a plain pass-through.
`timescale 1ns / 1ps

module fxalu_cell #(
    parameter int WORD_WIDTH = fxalu_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  fxalu_pkg::ctl_t                  ctl_in,
    input  logic [WORD_WIDTH+FRAC_BITS-1:0]  shreg_in,
    input  logic [WORD_WIDTH+FRAC_BITS-1:0]  acc_in,
    input  logic [WORD_WIDTH-1:0]            m_in,
    input  logic [WORD_WIDTH-1:0]            plain_in,
    output fxalu_pkg::ctl_t                  ctl_out,
    output logic [WORD_WIDTH+FRAC_BITS-1:0]  shreg_out,
    output logic [WORD_WIDTH+FRAC_BITS-1:0]  acc_out,
    output logic [WORD_WIDTH-1:0]            m_out,
    output logic [WORD_WIDTH-1:0]            plain_out
);
    import fxalu_pkg::*;

    localparam int N = WORD_WIDTH + FRAC_BITS;

    ctl_t                  ctl_reg;
    logic [N-1:0]          shreg_reg;
    logic [N-1:0]          shreg_next;
    logic [N-1:0]          acc_reg;
    logic [N-1:0]          acc_next;
    logic [WORD_WIDTH-1:0] m_reg;
    logic [WORD_WIDTH-1:0] plain_reg;
    logic                  top;
    logic [WORD_WIDTH:0]   trial;

    // Step: shift the top bit out, then add the multiplicand or try the divisor
    always_comb
    begin
        top        = shreg_in[N-1];
        trial      = {acc_in[WORD_WIDTH-1:0], top} - {1'b0, m_in};
        shreg_next = shreg_in;
        acc_next   = acc_in;
        unique case (ctl_in.kind)
            KIND_MUL:
            begin
                shreg_next = {shreg_in[N-2:0], 1'b0};
                acc_next   = {acc_in[N-2:0], 1'b0} +
                             (top ? {{FRAC_BITS{1'b0}}, m_in} : {N{1'b0}});
            end
            KIND_DIV:
            begin
                if (!trial[WORD_WIDTH])
                begin
                    shreg_next = {shreg_in[N-2:0], 1'b1};
                    acc_next   = {{FRAC_BITS{1'b0}}, trial[WORD_WIDTH-1:0]};
                end
                else
                begin
                    shreg_next = {shreg_in[N-2:0], 1'b0};
                    acc_next   = {{FRAC_BITS{1'b0}}, acc_in[WORD_WIDTH-2:0], top};
                end
            end
            default:
            begin
                shreg_next = shreg_in;
                acc_next   = acc_in;
            end
        endcase
    end

    // Hold control in a reset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shreg_reg <= shreg_next;
            acc_reg   <= acc_next;
            m_reg     <= m_in;
            plain_reg <= plain_in;
        end
    end

    assign ctl_out   = ctl_reg;
    assign shreg_out = shreg_reg;
    assign acc_out   = acc_reg;
    assign m_out     = m_reg;
    assign plain_out = plain_reg;

endmodule

// ===== src/fxalu_post.sv =====
// Final sign fix and result selection at the end of the cell chain.
`timescale 1ns / 1ps

module fxalu_post #(
    parameter int WORD_WIDTH = fxalu_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = fxalu_pkg::FRAC_BITS_DEF
) (
    input  fxalu_pkg::ctl_t                  ctl,
    input  logic [WORD_WIDTH+FRAC_BITS-1:0]  shreg,
    input  logic [WORD_WIDTH+FRAC_BITS-1:0]  acc,
    input  logic [WORD_WIDTH-1:0]            plain,
    output logic [WORD_WIDTH-1:0]            result
);
    import fxalu_pkg::*;

    localparam int N = WORD_WIDTH + FRAC_BITS;

    logic [N-1:0]          prod;
    logic [WORD_WIDTH-1:0] quo;

    // Apply the sign to product and quotient
    always_comb
    begin
        prod = ctl.neg ? N'(-acc) : acc;
        quo  = ctl.neg ? WORD_WIDTH'(-shreg[WORD_WIDTH-1:0]) : shreg[WORD_WIDTH-1:0];
    end

    // Select the result of this beat
    always_comb
    begin
        unique case (ctl.kind)
            KIND_MUL: result = prod[N-1:FRAC_BITS];
            KIND_DIV: result = quo;
            default:  result = plain;
        endcase
    end

endmodule

// ===== src/fixed_point_alu_unit.sv =====
// Top level of the signed fixed-point ALU with a pipelined cell chain.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------------
//  in      | in_valid  | in_stall  | command, operand_a, operand_b
//  out     | out_valid | out_stall | result, a_greater, a_less, a_equal, divide_by_zero
//
// One beat enters per cycle while in_stall is low; a beat is registered in every
// cell of the chain and then in the output register. The chain has WORD_WIDTH +
// FRAC_BITS cells, one multiply or divide bit per cell; every command travels the
// same chain to keep order.
// Reset clears only the control words of the chain, output register and skid register.
// A skid register catches one beat when the output is stalled; in_stall is high
// while it holds a beat, and the whole chain holds with it.
`timescale 1ns / 1ps
`include "fixed_point_alu_unit_assert.svh"

module fixed_point_alu_unit #(
    parameter int WORD_WIDTH = fxalu_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fxalu_pkg::CMD_W-1:0]   command,
    input  logic signed [WORD_WIDTH-1:0]  operand_a,
    input  logic signed [WORD_WIDTH-1:0]  operand_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [WORD_WIDTH-1:0]  result,
    output logic                          a_greater,
    output logic                          a_less,
    output logic                          a_equal,
    output logic                          divide_by_zero
);
    import fxalu_pkg::*;

    localparam int N = WORD_WIDTH + FRAC_BITS;

    ctl_t                  ctl_s   [0:N];
    logic [N-1:0]          shreg_s [0:N];
    logic [N-1:0]          acc_s   [0:N];
    logic [WORD_WIDTH-1:0] m_s     [0:N];
    logic [WORD_WIDTH-1:0] plain_s [0:N];

    logic                  en;
    logic                  out_free;
    ctl_t                  exit_ctl;
    logic [WORD_WIDTH-1:0] exit_result;
    ctl_t                  out_ctl_reg;
    logic [WORD_WIDTH-1:0] out_result_reg;
    ctl_t                  skid_ctl_reg;
    logic [WORD_WIDTH-1:0] skid_result_reg;

    // Advance the chain while the skid register is empty
    assign en       = !skid_ctl_reg.valid;
    assign in_stall = skid_ctl_reg.valid;
    assign out_free = !out_ctl_reg.valid || !out_stall;

    fxalu_prep #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_prep (
        .in_valid  (in_valid),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctl       (ctl_s[0]),
        .shreg     (shreg_s[0]),
        .m         (m_s[0]),
        .plain     (plain_s[0])
    );

    assign acc_s[0] = '0;

    // Build the row of cells
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        fxalu_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .ctl_in    (ctl_s[k]),
            .shreg_in  (shreg_s[k]),
            .acc_in    (acc_s[k]),
            .m_in      (m_s[k]),
            .plain_in  (plain_s[k]),
            .ctl_out   (ctl_s[k+1]),
            .shreg_out (shreg_s[k+1]),
            .acc_out   (acc_s[k+1]),
            .m_out     (m_s[k+1]),
            .plain_out (plain_s[k+1])
        );
    end

    fxalu_post #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_post (
        .ctl    (ctl_s[N]),
        .shreg  (shreg_s[N]),
        .acc    (acc_s[N]),
        .plain  (plain_s[N]),
        .result (exit_result)
    );

    // Hide the exit beat from the output side while the chain holds
    always_comb
    begin
        exit_ctl       = ctl_s[N];
        exit_ctl.valid = ctl_s[N].valid && en;
    end

    // Move beats into the output register, or park one in the skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg  <= '0;
            skid_ctl_reg <= '0;
        end
        else if (out_free)
        begin
            if (skid_ctl_reg.valid)
            begin
                out_ctl_reg        <= skid_ctl_reg;
                skid_ctl_reg.valid <= 1'b0;
            end
            else
            begin
                out_ctl_reg <= exit_ctl;
            end
        end
        else if (exit_ctl.valid)
        begin
            skid_ctl_reg <= exit_ctl;
        end
    end

    // Follow the same moves for the result word
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_ctl_reg.valid)
            begin
                out_result_reg <= skid_result_reg;
            end
            else
            begin
                out_result_reg <= exit_result;
            end
        end
        else if (exit_ctl.valid)
        begin
            skid_result_reg <= exit_result;
        end
    end

    assign out_valid      = out_ctl_reg.valid;
    assign result         = out_result_reg;
    assign a_greater      = out_ctl_reg.gt;
    assign a_less         = out_ctl_reg.lt;
    assign a_equal        = out_ctl_reg.eq;
    assign divide_by_zero = out_ctl_reg.dz;

    `FXALU_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_ctl_reg.valid, out_ctl_reg.valid)
    `FXALU_ASSERT_IMP(a_skid_fill, clk, rst_n, $rose(skid_ctl_reg.valid), $past(out_ctl_reg.valid && out_stall))
    `FXALU_ASSERT_NXT(a_skid_hold, clk, rst_n, skid_ctl_reg.valid && out_stall, skid_ctl_reg.valid)
    `FXALU_ASSERT_IMP(a_flags_onehot, clk, rst_n, out_valid, $onehot({a_greater, a_less, a_equal}))
    `FXALU_ASSERT_IMP(a_dz_zero, clk, rst_n, out_valid && divide_by_zero, result == '0)

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the signed fixed-point ALU unit.
`timescale 1ns / 1ps

module tb;
    import fxalu_pkg::*;

    localparam int W            = WORD_WIDTH_DEF;
    localparam int FB           = FRAC_BITS_DEF;
    localparam int PERIOD       = 12;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = W + FB + 1 + 24;
    localparam int PHASE_BEATS  = 300;
    localparam int NUM_PHASES   = 4;
    localparam int NUM_ROWS     = 26;

    // Command codes past the last defined command
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd10;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

    localparam logic signed [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] WORD_MAX = ~WORD_MIN;
    localparam logic signed [W-1:0] FX_ONE   = 1 <<< FB;
    localparam logic signed [W-1:0] FX_M_ONE = -(1 <<< FB);

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                gt;
        logic                lt;
        logic                eq;
        logic                dz;
    } alu_out_t;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        bit                  typed;
        alu_out_t            want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    command;
    logic signed [W-1:0] operand_a;
    logic signed [W-1:0] operand_b;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [W-1:0] result;
    logic                a_greater;
    logic                a_less;
    logic                a_equal;
    logic                divide_by_zero;

    alu_out_t pending_results[$];
    int       mismatches    = 0;
    int       send_idle_pct = 0;
    int       stall_pct     = 0;

    // Directed rows: extremes, every command, divide by zero and overflow, spare codes
    stim_row_t dir_rows [NUM_ROWS] = '{
        '{CMD_ADD,      32'sh0,     32'sh0,     1'b1, '{32'sh0,     1'b0, 1'b0, 1'b1, 1'b0}},
        '{CMD_ADD,      WORD_MAX,   32'sh1,     1'b1, '{WORD_MIN,   1'b1, 1'b0, 1'b0, 1'b0}},
        '{CMD_SUB,      WORD_MIN,   32'sh1,     1'b1, '{WORD_MAX,   1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_SUB,      32'sh12345, WORD_MIN,   1'b0, '0},
        '{CMD_MUL,      FX_ONE,     FX_ONE,     1'b1, '{FX_ONE,     1'b0, 1'b0, 1'b1, 1'b0}},
        '{CMD_MUL,      WORD_MAX,   WORD_MAX,   1'b0, '0},
        '{CMD_MUL,      WORD_MIN,   WORD_MIN,   1'b0, '0},
        '{CMD_MUL,      WORD_MIN,   -32'sh1,    1'b0, '0},
        '{CMD_MUL,      -32'sh180,  32'sh280,   1'b0, '0},
        '{CMD_DIV,      FX_ONE,     32'sh0,     1'b1, '{32'sh0,     1'b1, 1'b0, 1'b0, 1'b1}},
        '{CMD_DIV,      WORD_MIN,   32'sh0,     1'b1, '{32'sh0,     1'b0, 1'b1, 1'b0, 1'b1}},
        '{CMD_DIV,      32'sh200,   FX_ONE,     1'b1, '{32'sh200,   1'b1, 1'b0, 1'b0, 1'b0}},
        '{CMD_DIV,      WORD_MIN,   -32'sh1,    1'b0, '0},
        '{CMD_DIV,      WORD_MAX,   32'sh1,     1'b0, '0},
        '{CMD_DIV,      FX_M_ONE,   32'sh300,   1'b0, '0},
        '{CMD_MIN,      WORD_MIN,   WORD_MAX,   1'b1, '{WORD_MIN,   1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_MAX,      WORD_MIN,   WORD_MAX,   1'b1, '{WORD_MAX,   1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_MIN,      -32'sh5,    -32'sh5,    1'b1, '{-32'sh5,    1'b0, 1'b0, 1'b1, 1'b0}},
        '{CMD_INC,      WORD_MAX,   32'sh0,     1'b1, '{WORD_MIN,   1'b1, 1'b0, 1'b0, 1'b0}},
        '{CMD_DEC,      WORD_MIN,   32'sh0,     1'b1, '{WORD_MAX,   1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_FROM_INT, 32'sh1,     32'sh0,     1'b1, '{FX_ONE,     1'b1, 1'b0, 1'b0, 1'b0}},
        '{CMD_FROM_INT, -32'sh1,    -32'sh1,    1'b1, '{FX_M_ONE,   1'b0, 1'b0, 1'b1, 1'b0}},
        '{CMD_TO_INT,   WORD_MIN,   WORD_MAX,   1'b1, '{32'shff800000, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_TO_INT,   FX_M_ONE,   32'sh0,     1'b1, '{-32'sh1,    1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_SPARE_LO, WORD_MAX,   WORD_MIN,   1'b1, '{32'sh0,     1'b1, 1'b0, 1'b0, 1'b0}},
        '{CMD_SPARE_HI, -32'sh1,    32'sh1,     1'b1, '{32'sh0,     1'b0, 1'b1, 1'b0, 1'b0}}
    };

    fixed_point_alu_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result),
        .a_greater      (a_greater),
        .a_less         (a_less),
        .a_equal        (a_equal),
        .divide_by_zero (divide_by_zero)
    );

    // Work out the ALU result and compare flags for one beat
    function automatic alu_out_t alu_predict(input logic [CMD_W-1:0] cmd,
                                             input logic signed [W-1:0] a,
                                             input logic signed [W-1:0] b);
        longint   wide_a;
        longint   wide_b;
        longint   wide_r;
        alu_out_t r;
        wide_a = longint'(a);
        wide_b = longint'(b);
        r      = '0;
        r.gt   = a > b;
        r.lt   = a < b;
        r.eq   = a == b;
        case (cmd)
            CMD_ADD:      r.value = a + b;
            CMD_SUB:      r.value = a - b;
            CMD_MUL:
            begin
                wide_r  = wide_a * wide_b;
                r.value = wide_r[W+FB-1:FB];
            end
            CMD_DIV:
            begin
                // Zero divisor flags and returns zero; quotient truncates toward zero
                if (b == 0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    wide_r  = (wide_a <<< FB) / wide_b;
                    r.value = wide_r[W-1:0];
                end
            end
            CMD_MIN:      r.value = r.lt ? a : b;
            CMD_MAX:      r.value = r.gt ? a : b;
            CMD_INC:      r.value = a + 1;
            CMD_DEC:      r.value = a - 1;
            CMD_FROM_INT: r.value = a <<< FB;
            CMD_TO_INT:   r.value = a >>> FB;
            default:      r.value = '0;
        endcase
        return r;
    endfunction

    // Pick an operand: extremes, small values near zero, or any word
    function automatic logic signed [W-1:0] rand_operand();
        logic signed [W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 6))
                    0:       v = WORD_MIN;
                    1:       v = WORD_MAX;
                    2:       v = FX_ONE;
                    3:       v = FX_M_ONE;
                    4:       v = 1;
                    5:       v = -1;
                    default: v = 0;
                endcase
            end
            1, 2, 3: v = $signed($urandom_range(0, 8191)) - 4096;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Drive one beat on the input channel and record what it should produce
    task automatic send_beat(input logic [CMD_W-1:0] cmd,
                             input logic signed [W-1:0] a,
                             input logic signed [W-1:0] b,
                             input bit typed,
                             input alu_out_t want);
        int gaps;
        gaps = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gaps++;
        if (gaps > 0)
        begin
            in_valid = 1'b0;
            repeat (gaps) @(negedge clk);
        end
        in_valid  = 1'b1;
        command   = cmd;
        operand_a = a;
        operand_b = b;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(typed ? want : alu_predict(cmd, a, b));
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    // Stall the output channel at random
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // Compare every accepted result beat with the oldest pending one
    always @(posedge clk)
    begin : check_results
        alu_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat: expected none, actual result %h", $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.value)
                begin
                    mismatches++;
                    $display("%0t: result: expected %h, actual %h", $time, want.value, result);
                end
                if (a_greater !== want.gt)
                begin
                    mismatches++;
                    $display("%0t: a_greater: expected %b, actual %b", $time, want.gt, a_greater);
                end
                if (a_less !== want.lt)
                begin
                    mismatches++;
                    $display("%0t: a_less: expected %b, actual %b", $time, want.lt, a_less);
                end
                if (a_equal !== want.eq)
                begin
                    mismatches++;
                    $display("%0t: a_equal: expected %b, actual %b", $time, want.eq, a_equal);
                end
                if (divide_by_zero !== want.dz)
                begin
                    mismatches++;
                    $display("%0t: divide_by_zero: expected %b, actual %b",
                             $time, want.dz, divide_by_zero);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [CMD_W-1:0]    cmd;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = '0;
        operand_a = '0;
        operand_b = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table back to back
        foreach (dir_rows[i])
            send_beat(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b,
                      dir_rows[i].typed, dir_rows[i].want);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 68; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            repeat (PHASE_BEATS)
            begin
                if ($urandom_range(0, 99) < 88)
                    cmd = CMD_W'($urandom_range(CMD_ADD, CMD_TO_INT));
                else
                    cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                a = rand_operand();
                if ($urandom_range(0, 9) == 0)
                    b = a;
                else if (cmd == CMD_DIV && $urandom_range(0, 9) == 0)
                    b = '0;
                else
                    b = rand_operand();
                send_beat(cmd, a, b, 1'b0, '0);
            end
            // Hold off the sender until the pipe has drained
            in_valid = 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches += pending_results.size();
            $display("%0t: results still pending: expected 0, actual %0d",
                     $time, pending_results.size());
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== fixed_point_alu_unit.f =====
+incdir+src
src/fxalu_pkg.sv
src/fxalu_prep.sv
src/fxalu_cell.sv
src/fxalu_post.sv
src/fixed_point_alu_unit.sv
bench/tb.sv
